[rtl/core/msst_pkg.sv]
package msst_pkg;

    localparam int OP_W         = 2;
    localparam int GROUP_FIELD_W = 16;
    localparam int COEF_FIELD_W  = 32;
    localparam int STATUS_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_UPSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PRUNE  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_EXEC,
        S_MV_WRITE,
        S_PR_CHECK,
        S_PR_LOAD,
        S_PR_DECIDE,
        S_PR_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [GROUP_FIELD_W-1:0] out_group;
        logic [GROUP_FIELD_W-1:0] in_group;
        logic                     mute_flag;
        logic                     solo_flag;
        logic [COEF_FIELD_W-1:0]  coef_left;
        logic [COEF_FIELD_W-1:0]  coef_right;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic                    found;
        logic                    suppressed;
        logic [COEF_FIELD_W-1:0] nominal_left;
        logic [COEF_FIELD_W-1:0] nominal_right;
        logic [COEF_FIELD_W-1:0] effective_left;
        logic [COEF_FIELD_W-1:0] effective_right;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_req;
        logic    scan_start;
        logic    rd_last;
        logic    wr_upsert;
        logic    wr_move;
        logic    move_to_hit;
        logic    count_inc;
        logic    count_dec;
        logic    cur_load;
        logic    cur_clear;
        logic    cur_next;
        logic    set_status;
        status_t status;
        logic    res_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic zero_id;
        logic scan_done;
        logic hit;
        logic full;
        logic cur_end;
        logic cur_keep;
        logic bus_solo;
        logic out_free;
    } dp_sts_t;

endpackage

[rtl/core/msst_if.sv]
interface msst_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [msst_pkg::OP_W-1:0]            op;
    logic [msst_pkg::GROUP_FIELD_W-1:0]   out_group;
    logic [msst_pkg::GROUP_FIELD_W-1:0]   in_group;
    logic                                 mute_flag;
    logic                                 solo_flag;
    logic [msst_pkg::COEF_FIELD_W-1:0]    coef_left;
    logic [msst_pkg::COEF_FIELD_W-1:0]    coef_right;

    modport source (
        output valid, op, out_group, in_group, mute_flag, solo_flag, coef_left, coef_right,
        input  ready
    );
    modport sink (
        input  valid, op, out_group, in_group, mute_flag, solo_flag, coef_left, coef_right,
        output ready
    );
endinterface

interface msst_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [msst_pkg::STATUS_W-1:0]        status;
    logic                                 found;
    logic                                 suppressed;
    logic [msst_pkg::COEF_FIELD_W-1:0]    nominal_left;
    logic [msst_pkg::COEF_FIELD_W-1:0]    nominal_right;
    logic [msst_pkg::COEF_FIELD_W-1:0]    effective_left;
    logic [msst_pkg::COEF_FIELD_W-1:0]    effective_right;

    modport source (
        output valid, status, found, suppressed, nominal_left, nominal_right,
               effective_left, effective_right,
        input  ready
    );
    modport sink (
        input  valid, status, found, suppressed, nominal_left, nominal_right,
               effective_left, effective_right,
        output ready
    );
endinterface

[rtl/core/msst_ram.sv]
module msst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

[rtl/core/msst_datapath.sv]
module msst_datapath #(
    parameter int DEPTH = 64,
    parameter int GW    = 16,
    parameter int CW    = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  msst_pkg::dp_cmd_t cmd,
    output msst_pkg::dp_sts_t sts,
    input  msst_pkg::req_t    req_bus,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output msst_pkg::rsp_t    rsp_bus
);
    import msst_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EW    = 2 * GW + 2 + 2 * CW;

    // request copy; og_reg doubles as the bus key of the entry under prune
    op_t            op_reg;
    logic [GW-1:0]  og_reg;
    logic [GW-1:0]  ig_reg;
    logic           mute_reg;
    logic           solo_reg;
    logic [CW-1:0]  cl_reg;
    logic [CW-1:0]  cr_reg;
    status_t        status_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] cur_idx_reg;
    logic             cur_keep_reg;

    logic [IDX_W-1:0] scan_addr_reg;
    logic             scan_run_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic             hit_reg;
    logic             bus_solo_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             hit_mute_reg;
    logic             hit_solo_reg;
    logic [CW-1:0]    hit_cl_reg;
    logic [CW-1:0]    hit_cr_reg;

    logic             out_valid_reg;
    rsp_t             res_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [EW-1:0]    wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [EW-1:0]    rd_data;

    logic [GW-1:0]    rd_og;
    logic [GW-1:0]    rd_ig;
    logic             rd_mute;
    logic             rd_solo;
    logic [CW-1:0]    rd_cl;
    logic [CW-1:0]    rd_cr;
    logic             key_match;
    logic             is_query;
    logic             supp;
    logic [CW-1:0]    nom_l;
    logic [CW-1:0]    nom_r;

    assign rd_og   = rd_data[EW-1 -: GW];
    assign rd_ig   = rd_data[EW-GW-1 -: GW];
    assign rd_mute = rd_data[2*CW+1];
    assign rd_solo = rd_data[2*CW];
    assign rd_cl   = rd_data[2*CW-1 -: CW];
    assign rd_cr   = rd_data[CW-1:0];

    msst_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (scan_run_reg)
        begin
            rd_addr = scan_addr_reg;
        end
        else if (cmd.rd_last)
        begin
            rd_addr = IDX_W'(count_reg - CNT_W'(1));
        end
        else
        begin
            rd_addr = IDX_W'(cur_idx_reg);
        end
    end

    assign wr_en = cmd.wr_upsert | cmd.wr_move;

    always_comb
    begin
        if (cmd.wr_upsert)
        begin
            wr_addr = hit_reg ? hit_idx_reg : IDX_W'(count_reg);
            wr_data = {og_reg, ig_reg, mute_reg, solo_reg, cl_reg, cr_reg};
        end
        else
        begin
            wr_addr = cmd.move_to_hit ? hit_idx_reg : IDX_W'(cur_idx_reg);
            wr_data = rd_data;
        end
    end

    assign key_match = (rd_og == og_reg) && (rd_ig == ig_reg);

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg   <= op_t'(req_bus.op);
            og_reg   <= GW'(req_bus.out_group);
            ig_reg   <= GW'(req_bus.in_group);
            mute_reg <= req_bus.mute_flag;
            solo_reg <= req_bus.solo_flag;
            cl_reg   <= CW'(req_bus.coef_left);
            cr_reg   <= CW'(req_bus.coef_right);
        end
        else if (cmd.cur_load)
        begin
            og_reg <= rd_og;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            status_reg <= ST_DONE;
        end
        else if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.cur_load)
        begin
            cur_keep_reg <= rd_mute | rd_solo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            cur_idx_reg <= '0;
        end
        else
        begin
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.cur_clear)
            begin
                cur_idx_reg <= '0;
            end
            else if (cmd.cur_next)
            begin
                cur_idx_reg <= cur_idx_reg + CNT_W'(1);
            end
        end
    end

    // scan: one address issued a cycle, compared in the cycle after, against the registered RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            scan_run_reg  <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            bus_solo_reg  <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_addr_reg <= '0;
            scan_run_reg  <= (count_reg != '0);
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            bus_solo_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= scan_run_reg;
            rd_idx_reg <= scan_addr_reg;
            if (scan_run_reg)
            begin
                scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                if (CNT_W'(scan_addr_reg) == count_reg - CNT_W'(1))
                begin
                    scan_run_reg <= 1'b0;
                end
            end
            if (rd_vld_reg && key_match)
            begin
                hit_reg <= 1'b1;
            end
            if (rd_vld_reg && (rd_og == og_reg) && rd_solo)
            begin
                bus_solo_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && key_match && !cmd.scan_start)
        begin
            hit_idx_reg  <= rd_idx_reg;
            hit_mute_reg <= rd_mute;
            hit_solo_reg <= rd_solo;
            hit_cl_reg   <= rd_cl;
            hit_cr_reg   <= rd_cr;
        end
    end

    // result
    assign is_query = (op_reg == OP_QUERY);
    assign supp     = hit_reg ? (hit_mute_reg | (bus_solo_reg & ~hit_solo_reg)) : bus_solo_reg;
    assign nom_l    = hit_reg ? hit_cl_reg : cl_reg;
    assign nom_r    = hit_reg ? hit_cr_reg : cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_reg.status          <= status_reg;
            res_reg.found           <= is_query & hit_reg;
            res_reg.suppressed      <= is_query & supp;
            res_reg.nominal_left    <= is_query ? COEF_FIELD_W'(nom_l) : '0;
            res_reg.nominal_right   <= is_query ? COEF_FIELD_W'(nom_r) : '0;
            res_reg.effective_left  <= (is_query && !supp) ? COEF_FIELD_W'(nom_l) : '0;
            res_reg.effective_right <= (is_query && !supp) ? COEF_FIELD_W'(nom_r) : '0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_bus   = res_reg;

    assign sts.op        = op_reg;
    assign sts.zero_id   = (og_reg == '0) || (ig_reg == '0);
    assign sts.scan_done = !scan_run_reg && !rd_vld_reg;
    assign sts.hit       = hit_reg;
    assign sts.full      = (count_reg == CNT_W'(DEPTH));
    assign sts.cur_end   = (cur_idx_reg >= count_reg);
    assign sts.cur_keep  = cur_keep_reg;
    assign sts.bus_solo  = bus_solo_reg;
    assign sts.out_free  = !out_valid_reg || rsp_ready;
endmodule

[rtl/core/msst_ctrl.sv]
module msst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  msst_pkg::dp_sts_t sts,
    output msst_pkg::dp_cmd_t cmd
);
    import msst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (sts.op)
                    OP_UPSERT:
                    begin
                        if (sts.zero_id)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BAD_ID;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    OP_PRUNE:
                    begin
                        cmd.cur_clear = 1'b1;
                        state_next    = S_PR_CHECK;
                    end
                    default:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (sts.op)
                    OP_UPSERT:
                    begin
                        if (sts.hit)
                        begin
                            cmd.wr_upsert = 1'b1;
                        end
                        else if (sts.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_upsert = 1'b1;
                            cmd.count_inc = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (sts.hit)
                        begin
                            cmd.rd_last = 1'b1;
                            state_next  = S_MV_WRITE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // last entry has been read, drop it into the freed slot
            S_MV_WRITE:
            begin
                cmd.wr_move     = 1'b1;
                cmd.count_dec   = 1'b1;
                cmd.move_to_hit = (sts.op == OP_REMOVE);
                state_next      = (sts.op == OP_REMOVE) ? S_DONE : S_PR_CHECK;
            end

            S_PR_CHECK:
            begin
                state_next = sts.cur_end ? S_DONE : S_PR_LOAD;
            end

            S_PR_LOAD:
            begin
                cmd.cur_load = 1'b1;
                state_next   = S_PR_DECIDE;
            end

            S_PR_DECIDE:
            begin
                if (sts.cur_keep)
                begin
                    cmd.cur_next = 1'b1;
                    state_next   = S_PR_CHECK;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_PR_SCAN;
                end
            end

            S_PR_SCAN:
            begin
                if (sts.scan_done)
                begin
                    if (sts.bus_solo)
                    begin
                        cmd.cur_next = 1'b1;
                        state_next   = S_PR_CHECK;
                    end
                    else
                    begin
                        cmd.rd_last = 1'b1;
                        state_next  = S_MV_WRITE;
                    end
                end
            end

            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

[rtl/core/mute_solo_strip_state_table.sv]
// Upsert, query and remove scan the held entries once; a remove that hits also moves the last
// entry into the freed slot, and an upsert with a zero group id is refused without a scan.
// Prune walks the entries in turn and may rescan the table for each one.
// Throughput: one request at a time, the table scanned one entry a cycle; the next request
// is taken while the previous result still waits in the output register.
// Reset (async, active low) empties the table at once; entry contents are left as they are.
module mute_solo_strip_state_table #(
    parameter int TABLE_DEPTH   = 64,
    parameter int GROUP_ID_BITS = 16,
    parameter int COEF_BITS     = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    msst_req_if.sink   req,
    msst_rsp_if.source rsp
);
    import msst_pkg::*;

    req_t    req_bus;
    rsp_t    rsp_bus;
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    req_ready;
    logic    rsp_valid;

    assign req_bus.op         = req.op;
    assign req_bus.out_group  = req.out_group;
    assign req_bus.in_group   = req.in_group;
    assign req_bus.mute_flag  = req.mute_flag;
    assign req_bus.solo_flag  = req.solo_flag;
    assign req_bus.coef_left  = req.coef_left;
    assign req_bus.coef_right = req.coef_right;
    assign req.ready          = req_ready;

    assign rsp.valid           = rsp_valid;
    assign rsp.status          = rsp_bus.status;
    assign rsp.found           = rsp_bus.found;
    assign rsp.suppressed      = rsp_bus.suppressed;
    assign rsp.nominal_left    = rsp_bus.nominal_left;
    assign rsp.nominal_right   = rsp_bus.nominal_right;
    assign rsp.effective_left  = rsp_bus.effective_left;
    assign rsp.effective_right = rsp_bus.effective_right;

    msst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    msst_datapath #(
        .DEPTH (TABLE_DEPTH),
        .GW    (GROUP_ID_BITS),
        .CW    (COEF_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_bus   (req_bus),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp_valid),
        .rsp_bus   (rsp_bus)
    );
endmodule

[rtl/core/msst_checker.sv]
module msst_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic [msst_pkg::STATUS_W-1:0]       rsp_status,
    input logic                                rsp_found,
    input logic                                rsp_suppressed,
    input logic [msst_pkg::COEF_FIELD_W-1:0]   nominal_left,
    input logic [msst_pkg::COEF_FIELD_W-1:0]   nominal_right,
    input logic [msst_pkg::COEF_FIELD_W-1:0]   effective_left,
    input logic [msst_pkg::COEF_FIELD_W-1:0]   effective_right
);
    import msst_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(nominal_left)
                                   && $stable(effective_right))
        else $error("stalled result changed");

    // one request in flight: a request is never followed by another on the next edge
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_gain_gate: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_suppressed ? (effective_left == '0 && effective_right == '0)
                                      : (effective_left == nominal_left
                                         && effective_right == nominal_right)))
        else $error("effective coefficients disagree with suppression");

    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_BAD_ID || rsp_status == ST_FULL)
            |-> !rsp_found && !rsp_suppressed && nominal_left == '0 && nominal_right == '0)
        else $error("refused upsert carried query fields");
endmodule

bind mute_solo_strip_state_table msst_checker u_msst_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found       (rsp.found),
    .rsp_suppressed  (rsp.suppressed),
    .nominal_left    (rsp.nominal_left),
    .nominal_right   (rsp.nominal_right),
    .effective_left  (rsp.effective_left),
    .effective_right (rsp.effective_right)
);
